// ----- rtl/core/lrucb_pkg.sv -----
`timescale 1ns / 1ps
// shared constants and types for the byte-budget lru cache
package lrucb_pkg;
    localparam int SLOTS = 16;
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_TRIM   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;
    localparam logic REG_ENTRY_LIMIT = 1'b0;
    localparam logic REG_BYTE_BUDGET = 1'b1;

    typedef struct packed {
        logic          found;
        logic [IW-1:0] idx;
    } scan_res_t;
endpackage

// ----- rtl/core/lrucb_scan.sv -----
`timescale 1ns / 1ps
// sequential slot scanner: one slot per cycle while step is high, finds key match, free slot and oldest slot
module lrucb_scan
    import lrucb_pkg::*;
(
    input  logic            aclk,
    input  logic            start,
    input  logic            step,
    input  logic [IW-1:0]   idx,
    input  logic            slot_valid,
    input  logic            key_eq,
    input  logic [IW-1:0]   slot_rank,
    output scan_res_t       match,
    output scan_res_t       free_slot,
    output scan_res_t       oldest
);
    scan_res_t match_reg, free_reg, old_reg;
    logic [IW-1:0] old_rank_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            match_reg <= '0;
            free_reg <= '0;
            old_reg <= '0;
            old_rank_reg <= '0;
        end else if (step) begin
            if (slot_valid && key_eq && !match_reg.found) begin
                match_reg <= '{found: 1'b1, idx: idx};
            end
            if (!slot_valid && !free_reg.found) begin
                free_reg <= '{found: 1'b1, idx: idx};
            end
            if (slot_valid && (!old_reg.found || slot_rank > old_rank_reg)) begin
                old_reg <= '{found: 1'b1, idx: idx};
                old_rank_reg <= slot_rank;
            end
        end
    end

    assign match = match_reg;
    assign free_slot = free_reg;
    assign oldest = old_reg;
endmodule

// ----- rtl/core/lru_cache_byte_budget.sv -----
`timescale 1ns / 1ps
// top level of the byte-budget lru cache
// lookup and clear: the slot scan (ST_SCAN), the action (ST_ACT), then the result (ST_OUT)
// a new-key insert and trim add a check (ST_CHECK) and, per eviction, a rescan (ST_EVSC)
// and a drop (ST_DROP); an insert into a full table first drops the oldest and rescans
// one item at a time: ready drops from acceptance until the result is taken
// reset (sync, active low) clears valid bits, ages, counts and limit; budget to all ones
module lru_cache_byte_budget (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [63:0] s_key,
    input  logic [31:0] s_handle_in,
    input  logic [23:0] s_entry_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [31:0] m_handle_out,
    output logic [4:0]  m_entry_count,
    output logic [31:0] m_bytes_held,
    output logic [4:0]  m_evicted_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import lrucb_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_ACT   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_EVSC  = 3'd4;
    localparam logic [2:0] ST_DROP  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [63:0]   key_mem [SLOTS];
    logic [31:0]   handle_mem [SLOTS];
    logic [23:0]   size_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [IW-1:0] rank_reg [SLOTS];

    logic [2:0]    state_reg;
    logic [IW:0]   cnt_reg;
    logic [1:0]    act_reg;
    logic [63:0]   key_reg;
    logic [31:0]   hin_reg;
    logic [23:0]   bytes_reg;
    logic [31:0]   total_reg;
    logic [CW-1:0] vcount_reg;
    logic [4:0]    limit_reg;
    logic [31:0]   budget_reg;
    logic          hit_reg;
    logic [31:0]   hout_reg;
    logic [4:0]    evict_reg;
    logic          ins_evict_reg;

    logic          sc_start, sc_step;
    logic [IW-1:0] sc_idx;
    scan_res_t     match, free_slot, oldest;
    logic          over;
    logic [32:0]   sum;

    assign sc_idx = cnt_reg[IW-1:0];
    assign sc_start = (state_reg == ST_IDLE) || (state_reg == ST_CHECK);
    assign sc_step = (state_reg == ST_SCAN || state_reg == ST_EVSC) && !cnt_reg[IW];

    lrucb_scan u_scan (
        .aclk(aclk), .start(sc_start), .step(sc_step), .idx(sc_idx),
        .slot_valid(valid_reg[sc_idx]), .key_eq(key_mem[sc_idx] == key_reg),
        .slot_rank(rank_reg[sc_idx]), .match(match), .free_slot(free_slot),
        .oldest(oldest)
    );

    always_comb begin
        over = 1'b0;
        if (vcount_reg > CW'(1)) begin
            if (limit_reg != 5'd0 && 32'(vcount_reg) > 32'(limit_reg)) begin
                over = 1'b1;
            end else begin
                over = total_reg > budget_reg;
            end
        end
    end

    assign sum = {1'b0, total_reg} + {9'd0, bytes_reg};
    assign s_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid = (state_reg == ST_OUT);
    assign m_hit = hit_reg;
    assign m_handle_out = hout_reg;
    assign m_entry_count = 5'(vcount_reg);
    assign m_bytes_held = total_reg;
    assign m_evicted_count = evict_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            for (int j = 0; j < SLOTS; j++) rank_reg[j] <= '0;
            total_reg <= '0;
            vcount_reg <= '0;
            limit_reg <= '0;
            budget_reg <= 32'hFFFF_FFFF;
            cnt_reg <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_ENTRY_LIMIT) limit_reg <= cfg_data[4:0];
                else budget_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        act_reg <= s_action;
                        key_reg <= s_key;
                        hin_reg <= s_handle_in;
                        bytes_reg <= s_entry_bytes;
                        hit_reg <= 1'b0;
                        hout_reg <= '0;
                        evict_reg <= '0;
                        ins_evict_reg <= 1'b0;
                        cnt_reg <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (cnt_reg[IW]) state_reg <= ST_ACT;
                    else cnt_reg <= cnt_reg + 1'b1;
                end
                ST_ACT: begin
                    state_reg <= ST_OUT;
                    case (act_reg)
                        ACT_LOOKUP: begin
                            if (match.found) begin
                                hit_reg <= 1'b1;
                                hout_reg <= handle_mem[match.idx];
                                for (int j = 0; j < SLOTS; j++) begin
                                    if (valid_reg[j] && rank_reg[j] < rank_reg[match.idx])
                                        rank_reg[j] <= rank_reg[j] + 1'b1;
                                end
                                rank_reg[match.idx] <= '0;
                            end
                        end
                        ACT_INSERT: begin
                            if (match.found) begin
                                hit_reg <= 1'b1;
                            end else if (free_slot.found) begin
                                for (int j = 0; j < SLOTS; j++)
                                    if (valid_reg[j]) rank_reg[j] <= rank_reg[j] + 1'b1;
                                key_mem[free_slot.idx] <= key_reg;
                                handle_mem[free_slot.idx] <= hin_reg;
                                size_mem[free_slot.idx] <= bytes_reg;
                                valid_reg[free_slot.idx] <= 1'b1;
                                rank_reg[free_slot.idx] <= '0;
                                vcount_reg <= vcount_reg + 1'b1;
                                total_reg <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                                state_reg <= ST_CHECK;
                            end else begin
                                // full: drop the oldest first, then retry the insert
                                ins_evict_reg <= 1'b1;
                                state_reg <= ST_CHECK;
                            end
                        end
                        ACT_TRIM: state_reg <= ST_CHECK;
                        default: begin
                            valid_reg <= '0;
                            for (int j = 0; j < SLOTS; j++) rank_reg[j] <= '0;
                            total_reg <= '0;
                            vcount_reg <= '0;
                        end
                    endcase
                end
                ST_CHECK: begin
                    cnt_reg <= '0;
                    if (ins_evict_reg || over) state_reg <= ST_EVSC;
                    else state_reg <= ST_OUT;
                end
                ST_EVSC: begin
                    if (cnt_reg[IW]) state_reg <= ST_DROP;
                    else cnt_reg <= cnt_reg + 1'b1;
                end
                ST_DROP: begin
                    total_reg <= (size_mem[oldest.idx] > 24'(0) &&
                                  32'(size_mem[oldest.idx]) > total_reg) ? '0 :
                                 total_reg - 32'(size_mem[oldest.idx]);
                    valid_reg[oldest.idx] <= 1'b0;
                    rank_reg[oldest.idx] <= '0;
                    if (vcount_reg != '0) vcount_reg <= vcount_reg - 1'b1;
                    if (evict_reg != 5'd31) evict_reg <= evict_reg + 1'b1;
                    if (ins_evict_reg) begin
                        // slot freed, go back to place the new word
                        ins_evict_reg <= 1'b0;
                        act_reg <= ACT_INSERT;
                        cnt_reg <= '0;
                        state_reg <= ST_SCAN;
                    end else begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- test/lrucb_checker.sv -----
`timescale 1ns / 1ps
// checker for the byte-budget lru cache: predicts each result word and compares it
module lrucb_checker
    import lrucb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [63:0] s_key,
    input  logic [31:0] s_handle_in,
    input  logic [23:0] s_entry_bytes,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_hit,
    input  logic [31:0] m_handle_out,
    input  logic [4:0]  m_entry_count,
    input  logic [31:0] m_bytes_held,
    input  logic [4:0]  m_evicted_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic        hit;
        logic [31:0] handle;
        logic [4:0]  count;
        logic [31:0] bytes;
        logic [4:0]  evicted;
    } lookup_word_t;

    logic [63:0] c_key [SLOTS];
    logic [31:0] c_handle [SLOTS];
    logic [23:0] c_size [SLOTS];
    logic        c_valid [SLOTS];
    int          c_age [SLOTS];
    logic [31:0] c_bytes;
    int          c_count;
    logic [4:0]  c_limit;
    logic [31:0] c_budget;
    lookup_word_t expected_q [$];

    function automatic int find_slot(logic [63:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (c_valid[i] && c_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int oldest();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (c_valid[i] && (best < 0 || c_age[i] > c_age[best])) best = i;
        return best;
    endfunction

    function automatic void drop(int i);
        c_bytes = (c_size[i] > c_bytes) ? 32'd0 : c_bytes - c_size[i];
        c_valid[i] = 1'b0;
        c_age[i] = 0;
        if (c_count > 0) c_count--;
    endfunction

    function automatic int shed();
        int n;
        int v;
        n = 0;
        while (c_count > 1 && ((c_limit != 0 && c_count > c_limit) || c_bytes > c_budget)) begin
            v = oldest();
            if (v < 0) break;
            drop(v);
            n++;
        end
        return n;
    endfunction

    function automatic lookup_word_t predict(logic [1:0] act, logic [63:0] k,
                                             logic [31:0] h, logic [23:0] b);
        lookup_word_t w;
        int i;
        int ev;
        logic [32:0] sum;
        w = '0;
        ev = 0;
        case (act)
            ACT_LOOKUP: begin
                i = find_slot(k);
                if (i >= 0) begin
                    for (int j = 0; j < SLOTS; j++)
                        if (c_valid[j] && j != i && c_age[j] < c_age[i]) c_age[j]++;
                    c_age[i] = 0;
                    w.hit = 1'b1;
                    w.handle = c_handle[i];
                end
            end
            ACT_INSERT: begin
                if (find_slot(k) >= 0) begin
                    w.hit = 1'b1;
                end else begin
                    i = -1;
                    for (int j = SLOTS - 1; j >= 0; j--)
                        if (!c_valid[j]) i = j;
                    if (i < 0) begin
                        i = oldest();
                        drop(i);
                        ev++;
                    end
                    for (int j = 0; j < SLOTS; j++)
                        if (c_valid[j]) c_age[j]++;
                    c_key[i] = k;
                    c_handle[i] = h;
                    c_size[i] = b;
                    c_valid[i] = 1'b1;
                    c_age[i] = 0;
                    c_count++;
                    sum = {1'b0, c_bytes} + b;
                    c_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    ev += shed();
                end
            end
            ACT_TRIM: ev = shed();
            default: begin
                for (int j = 0; j < SLOTS; j++) begin
                    c_valid[j] = 1'b0;
                    c_age[j] = 0;
                end
                c_bytes = '0;
                c_count = 0;
            end
        endcase
        w.count = (c_count > 31) ? 5'd31 : 5'(c_count);
        w.bytes = c_bytes;
        w.evicted = (ev > 31) ? 5'd31 : 5'(ev);
        return w;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        lookup_word_t e;
        if (!aresetn) begin
            for (int j = 0; j < SLOTS; j++) begin
                c_valid[j] = 1'b0;
                c_age[j] = 0;
            end
            c_bytes = '0;
            c_count = 0;
            c_limit = '0;
            c_budget = 32'hFFFF_FFFF;
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ENTRY_LIMIT) c_limit = cfg_data[4:0];
                else c_budget = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_hit !== e.hit) begin
                        $error("hit: expected %0h actual %0h", e.hit, m_hit);
                        fail_count++;
                    end
                    if (m_handle_out !== e.handle) begin
                        $error("handle_out: expected %0h actual %0h", e.handle, m_handle_out);
                        fail_count++;
                    end
                    if (m_entry_count !== e.count) begin
                        $error("entry_count: expected %0d actual %0d", e.count, m_entry_count);
                        fail_count++;
                    end
                    if (m_bytes_held !== e.bytes) begin
                        $error("bytes_held: expected %0h actual %0h", e.bytes, m_bytes_held);
                        fail_count++;
                    end
                    if (m_evicted_count !== e.evicted) begin
                        $error("evicted_count: expected %0d actual %0d", e.evicted,
                               m_evicted_count);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(predict(s_action, s_key, s_handle_in, s_entry_bytes));
        end
    end
endmodule

// ----- test/tb_lru_cache_byte_budget.sv -----
`timescale 1ns / 1ps
// testbench top for the byte-budget lru cache: stimulus, reset and verdict
module tb_lru_cache_byte_budget;
    import lrucb_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_LOOKUP;
    logic [63:0] s_key = '0;
    logic [31:0] s_handle_in = '0;
    logic [23:0] s_entry_bytes = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_hit;
    logic [31:0] m_handle_out;
    logic [4:0]  m_entry_count;
    logic [31:0] m_bytes_held;
    logic [4:0]  m_evicted_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_ENTRY_LIMIT;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    bit          calm = 1'b0;
    logic [63:0] key_pool [8];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    lru_cache_byte_budget u_top (.*);

    lrucb_checker u_chk (.*);

    // result side stalls in bursts
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] d);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(logic [1:0] a, logic [63:0] k, logic [31:0] h, logic [23:0] b);
        int n;
        // the task always waits on the clock before driving, so valid is never dropped and raised in the same step
        n = 1;
        if (!calm && $urandom_range(0, 4) == 0) n = $urandom_range(1, 17);
        repeat (n) @(posedge aclk);
        s_action <= a;
        s_key <= k;
        s_handle_in <= h;
        s_entry_bytes <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_key();
        if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
        return key_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [23:0] pick_bytes();
        case ($urandom_range(0, 3))
            0: return 24'hFF_FFFF;
            1: return 24'($urandom);
            default: return 24'($urandom_range(0, 4096));
        endcase
    endfunction

    initial begin
        int r;
        logic [1:0] a;
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, duplicates, full table
        send_word(ACT_LOOKUP, '0, '0, '0);
        send_word(ACT_INSERT, '0, '0, '0);
        send_word(ACT_INSERT, '1, '1, '1);
        send_word(ACT_INSERT, '1, 32'h1234, 24'h10);
        send_word(ACT_LOOKUP, '1, '0, '0);
        send_word(ACT_LOOKUP, '0, '1, '1);
        for (int i = 0; i < 16; i++)
            send_word(ACT_INSERT, 64'(i + 100), 32'(i), 24'hFF_FFFF);
        send_word(ACT_TRIM, '0, '0, '0);
        send_word(ACT_CLEAR, '1, '1, '1);
        drain();
        write_reg(REG_ENTRY_LIMIT, 32'd3);
        write_reg(REG_BYTE_BUDGET, 32'd0);
        send_word(ACT_INSERT, 64'd1, 32'd1, 24'd5);
        send_word(ACT_INSERT, 64'd2, 32'd2, 24'd5);
        send_word(ACT_TRIM, '0, '0, '0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(REG_ENTRY_LIMIT, 32'd0); write_reg(REG_BYTE_BUDGET, '1); end
                1: begin
                    write_reg(REG_ENTRY_LIMIT, 32'd16);
                    write_reg(REG_BYTE_BUDGET, 32'd20000);
                end
                2: begin
                    write_reg(REG_ENTRY_LIMIT, 32'd31);
                    write_reg(REG_BYTE_BUDGET, 32'h0100_0000);
                end
                3: begin write_reg(REG_ENTRY_LIMIT, 32'd1); write_reg(REG_BYTE_BUDGET, 32'd0); end
                4: begin
                    write_reg(REG_ENTRY_LIMIT, $urandom_range(0, 31));
                    write_reg(REG_BYTE_BUDGET, $urandom);
                end
                default: begin
                    calm = 1'b1;
                    write_reg(REG_ENTRY_LIMIT, 32'd5);
                    write_reg(REG_BYTE_BUDGET, 32'd9000);
                end
            endcase
            for (int n = 0; n < 215; n++) begin
                r = $urandom_range(0, 99);
                a = (r < 45) ? ACT_LOOKUP : (r < 90) ? ACT_INSERT :
                    (r < 97) ? ACT_TRIM : ACT_CLEAR;
                send_word(a, pick_key(), $urandom, pick_bytes());
            end
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end
endmodule
